FILE: sv/stq_pkg.sv
// Shared types, sizes and codes for the sorted timer event queue.
// Used by the cell row, the top level and the port checker; depends on nothing.
package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KIND_BITS   = 4;
  localparam int CODE_BITS   = 8;
  localparam int DL_BITS     = 64;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_BITS = 3;
  localparam int CMD_BITS    = 2;

  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

  localparam logic [CMD_BITS-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_PEEK = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_POLL = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY   = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_SHOWN   = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EXPIRED = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_ADDED   = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 3'd4;

  typedef logic [2:0] cell_op_t;

  localparam cell_op_t OP_HOLD  = 3'd0;
  localparam cell_op_t OP_MATCH = 3'd1;
  localparam cell_op_t OP_DROP  = 3'd2;
  localparam cell_op_t OP_CMP   = 3'd3;
  localparam cell_op_t OP_INS   = 3'd4;
  localparam cell_op_t OP_POP   = 3'd5;

  typedef struct packed {
    logic [DL_BITS-1:0]   deadline;
    logic [KIND_BITS-1:0] kind;
    logic [CODE_BITS-1:0] code;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctl_t;

endpackage

FILE: sv/stq_cell.sv
// One slot of the sorted timer row: holds an entry and a flag bit.
// Depends on stq_pkg for the entry type and the cell operation codes.
module stq_cell (
  input  logic              clk,
  input  stq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  logic              drop_en,
  input  logic              prev_flag,
  input  stq_pkg::entry_t   prev_entry,
  input  stq_pkg::entry_t   next_entry,
  output stq_pkg::entry_t   entry,
  output logic              flag
);
  import stq_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_MATCH: begin
        flag <= occ && (entry.kind == ctl.new_entry.kind) &&
                (entry.code == ctl.new_entry.code);
      end
      OP_DROP: begin
        if (drop_en) begin
          entry <= next_entry;
        end
      end
      OP_CMP: begin
        flag <= !occ || (entry.deadline > ctl.new_entry.deadline);
      end
      OP_INS: begin
        if (prev_flag) begin
          entry <= prev_entry;
        end else if (flag) begin
          entry <= ctl.new_entry;
        end
      end
      OP_POP: begin
        entry <= next_entry;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/sorted_timer_event_queue.sv
// Top level of the sorted timer event queue: sequencer and the row of slot cells.
// Depends on stq_pkg and stq_cell.
//
// Usage: one command word enters on the cmd channel (cmd_valid, cmd_stall) and
// exactly one result word leaves on the res channel (res_valid, res_stall).
// Commands: add a timer, peek at the head, or poll the head against now_time.
// The queue is a row of QUEUE_DEPTH cells kept in deadline order; every cell
// moves data to or from its neighbors in the same cycle, so the time each step
// of a command takes does not depend on how many entries are pending.
// Steps from acceptance to res_valid: match, remove, compare, insert and result
// for add; head and result for peek and poll.
// A new command is taken only once the sequencer has returned to idle, so the
// block does not accept a command while an earlier one is still in progress.
// The result sits in an output register; while the receiver stalls, the block
// still accepts and processes the next command, then holds its result in the
// sequencer with cmd_stall high until the output register frees up.
// Reset empties the queue at once (the pending count goes to zero); slot
// contents are not cleared because only slots below the count are ever read.
module sorted_timer_event_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic [stq_pkg::CMD_BITS-1:0]     cmd,
  input  logic [stq_pkg::DL_BITS-1:0]      deadline,
  input  logic [stq_pkg::KIND_BITS-1:0]    timer_kind,
  input  logic [stq_pkg::CODE_BITS-1:0]    timer_code,
  input  logic [stq_pkg::DL_BITS-1:0]      now_time,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [stq_pkg::STATUS_BITS-1:0]  status,
  output logic [stq_pkg::DL_BITS-1:0]      head_deadline,
  output logic [stq_pkg::KIND_BITS-1:0]    head_kind,
  output logic [stq_pkg::CODE_BITS-1:0]    head_code,
  output logic [stq_pkg::CNT_BITS-1:0]     pending_count
);
  import stq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_DROP  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_HEAD  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             state;
  logic [CNT_BITS-1:0]    count;
  logic [CMD_BITS-1:0]    cmd_r;
  entry_t                 req;
  logic [DL_BITS-1:0]     now_r;
  logic [STATUS_BITS-1:0] fin_status;
  entry_t                 fin_head;

  cell_ctl_t              ctl;
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] flag_vec;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] drop_en;

  logic accept;
  logic out_free;
  logic pop_now;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign pop_now   = (cmd_r == CMD_POLL) && (count != '0) &&
                     (cell_entry[0].deadline < now_r);

  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.new_entry = req;
    case (state)
      S_MATCH: ctl.op = OP_MATCH;
      S_DROP:  ctl.op = OP_DROP;
      S_CMP:   ctl.op = OP_CMP;
      S_INS: begin
        if (count != FULL_CNT) begin
          ctl.op = OP_INS;
        end
      end
      S_HEAD: begin
        if (pop_now) begin
          ctl.op = OP_POP;
        end
      end
      default: ctl.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_f;

    assign occ[i]     = (CNT_BITS'(i) < count);
    assign drop_en[i] = |flag_vec[i:0];

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_f = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_f = flag_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    stq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .drop_en    (drop_en[i]),
      .prev_flag  (prev_f),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .flag       (flag_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (cmd == CMD_ADD) ? S_MATCH : S_HEAD;
          end
        end
        S_MATCH: state <= S_DROP;
        S_DROP: begin
          if (|flag_vec) begin
            count <= count - CNT_BITS'(1);
          end
          state <= S_CMP;
        end
        S_CMP: state <= S_INS;
        S_INS: begin
          if (count != FULL_CNT) begin
            count <= count + CNT_BITS'(1);
          end
          state <= S_DONE;
        end
        S_HEAD: begin
          if (pop_now) begin
            count <= count - CNT_BITS'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= cmd;
      req.deadline <= deadline;
      req.kind     <= timer_kind;
      req.code     <= timer_code;
      now_r        <= now_time;
    end

    if (state == S_INS) begin
      fin_status <= (count != FULL_CNT) ? STATUS_ADDED : STATUS_FULL;
      fin_head   <= '0;
    end

    if (state == S_HEAD) begin
      if (count == '0) begin
        fin_status <= STATUS_EMPTY;
        fin_head   <= '0;
      end else begin
        fin_status <= pop_now ? STATUS_EXPIRED : STATUS_SHOWN;
        fin_head   <= cell_entry[0];
      end
    end

    if (state == S_DONE && out_free) begin
      status        <= fin_status;
      head_deadline <= fin_head.deadline;
      head_kind     <= fin_head.kind;
      head_code     <= fin_head.code;
      pending_count <= count;
    end
  end

endmodule

FILE: sv/stq_checker.sv
// Port-level checker for the sorted timer event queue, bound to the top level.
// Depends on stq_pkg for sizes and status codes.
module stq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_stall,
  input logic [stq_pkg::STATUS_BITS-1:0]  status,
  input logic [stq_pkg::DL_BITS-1:0]      head_deadline,
  input logic [stq_pkg::KIND_BITS-1:0]    head_kind,
  input logic [stq_pkg::CODE_BITS-1:0]    head_code,
  input logic [stq_pkg::CNT_BITS-1:0]     pending_count
);
  import stq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) &&
    $stable(pending_count) && $stable(head_deadline))
    else $error("stalled result word changed");

  a_add_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == STATUS_ADDED || status == STATUS_FULL) |->
    head_deadline == '0 && head_kind == '0 && head_code == '0)
    else $error("add result carries a head entry");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STATUS_EMPTY |->
    pending_count == '0 && head_deadline == '0)
    else $error("empty result with entries pending");

  a_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STATUS_FULL |-> pending_count == FULL_CNT)
    else $error("full result while slots are free");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending_count <= FULL_CNT && status <= STATUS_FULL)
    else $error("result word out of range");

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (.*);
